// ===== design/dd_pkg.sv =====
// Package for the date difference and weekday block.
// Holds the lane result type, calendar tables and divide-by-100 constants.
// No dependencies.
`default_nettype none

package dd_pkg;

    localparam int unsigned YEAR_W = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W = 5;
    localparam int unsigned DNUM_W = 22;
    localparam int unsigned DIFF_W = 23;
    localparam int unsigned WDAY_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_REF_YEAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_DAY = 2'd2;

    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;
    localparam logic [YEAR_W-1:0] RST_REF_YEAR = 14'd2001;
    localparam logic [MONTH_W-1:0] RST_REF_MONTH = 4'd1;
    localparam logic [DAY_W-1:0] RST_REF_DAY = 5'd1;

    // Floor division by 100 for values below 2^14: (x * 5243) >> 19.
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam int unsigned DIV100_SHIFT = 19;
    localparam int unsigned PROD_W = YEAR_W + 13;
    localparam int unsigned QUOT_W = 8;

    // What one lane reports about one date.
    typedef struct packed {
        logic              valid;
        logic [DNUM_W-1:0] dnum;
        logic [2:0]        mod7;
    } t_lane_res;

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] s;
        case (m)
            4'd1: s = 9'd0;
            4'd2: s = 9'd31;
            4'd3: s = 9'd59;
            4'd4: s = 9'd90;
            4'd5: s = 9'd120;
            4'd6: s = 9'd151;
            4'd7: s = 9'd181;
            4'd8: s = 9'd212;
            4'd9: s = 9'd243;
            4'd10: s = 9'd273;
            4'd11: s = 9'd304;
            4'd12: s = 9'd334;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== design/date_difference_and_weekday.sv =====
// Top level of the Gregorian date difference and weekday block.
// Instantiates three dd_lane copies and dd_merge; depends on dd_pkg.
//
//  Channel   | Direction | Handshake                      | Payload
//  ----------+-----------+--------------------------------+-----------------------------------
//  request   | in        | start, busy (busy is always 0) | year/month/day of dates A and B
//  result    | out       | o_done, one-cycle strobe       | difference, weekdays, valid flags
//  config    | in        | i_cfg_we, i_cfg_idx            | i_cfg_data (reference date fields)
//
// A request is taken on every clock edge where start is high, so a new date pair can
// enter each cycle. Its result passes through three lane register stages (constant
// multiplies, day number sum, residue mod 7) and then the merge register.
// The receiver cannot stall, so busy stays low and nothing ever waits in the pipe.
// Reset clears the pipeline valid bits and loads the reference date 2001-01-01.
// The reference date must only be rewritten while no request is in flight.
`default_nettype none

module date_difference_and_weekday (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [dd_pkg::YEAR_W-1:0]           i_year_a,
    input  wire logic [dd_pkg::MONTH_W-1:0]          i_month_a,
    input  wire logic [dd_pkg::DAY_W-1:0]            i_day_a,
    input  wire logic [dd_pkg::YEAR_W-1:0]           i_year_b,
    input  wire logic [dd_pkg::MONTH_W-1:0]          i_month_b,
    input  wire logic [dd_pkg::DAY_W-1:0]            i_day_b,
    input  wire logic                                i_cfg_we,
    input  wire logic [dd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [dd_pkg::YEAR_W-1:0]           i_cfg_data,
    output logic                                     o_done,
    output logic signed [dd_pkg::DIFF_W-1:0]         o_day_difference,
    output logic [dd_pkg::WDAY_W-1:0]                o_weekday_a,
    output logic [dd_pkg::WDAY_W-1:0]                o_weekday_b,
    output logic                                     o_valid_a,
    output logic                                     o_valid_b
);

    // Reference date registers.
    logic [dd_pkg::YEAR_W-1:0]  r_ref_year;
    logic [dd_pkg::MONTH_W-1:0] r_ref_month;
    logic [dd_pkg::DAY_W-1:0]   r_ref_day;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_year <= dd_pkg::RST_REF_YEAR;
            r_ref_month <= dd_pkg::RST_REF_MONTH;
            r_ref_day <= dd_pkg::RST_REF_DAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dd_pkg::REG_REF_YEAR: begin
                    r_ref_year <= i_cfg_data;
                end
                dd_pkg::REG_REF_MONTH: begin
                    r_ref_month <= i_cfg_data[dd_pkg::MONTH_W-1:0];
                end
                dd_pkg::REG_REF_DAY: begin
                    r_ref_day <= i_cfg_data[dd_pkg::DAY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The pipeline never stalls, so a request is always taken.
    logic n_accept;
    logic [2:0] r_vld;

    assign busy = 1'b0;
    assign n_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], n_accept};
        end
    end

    // Zero fields fall back to the reference date before entering the lanes.
    logic [dd_pkg::YEAR_W-1:0]  n_ya;
    logic [dd_pkg::MONTH_W-1:0] n_ma;
    logic [dd_pkg::DAY_W-1:0]   n_da;
    logic [dd_pkg::YEAR_W-1:0]  n_yb;
    logic [dd_pkg::MONTH_W-1:0] n_mb;
    logic [dd_pkg::DAY_W-1:0]   n_db;

    always_comb begin
        n_ya = (i_year_a == '0) ? r_ref_year : i_year_a;
        n_ma = (i_month_a == '0) ? r_ref_month : i_month_a;
        n_da = (i_day_a == '0) ? r_ref_day : i_day_a;
        n_yb = (i_year_b == '0) ? r_ref_year : i_year_b;
        n_mb = (i_month_b == '0) ? r_ref_month : i_month_b;
        n_db = (i_day_b == '0) ? r_ref_day : i_day_b;
    end

    dd_pkg::t_lane_res lane_a;
    dd_pkg::t_lane_res lane_b;
    dd_pkg::t_lane_res lane_r;

    dd_lane u_lane_a (
        .i_clk   (i_clk),
        .i_year  (n_ya),
        .i_month (n_ma),
        .i_day   (n_da),
        .o_res   (lane_a)
    );

    dd_lane u_lane_b (
        .i_clk   (i_clk),
        .i_year  (n_yb),
        .i_month (n_mb),
        .i_day   (n_db),
        .o_res   (lane_b)
    );

    // The reference lane runs continuously; users must keep the registers steady while requests flow (unchecked).
    dd_lane u_lane_r (
        .i_clk   (i_clk),
        .i_year  (r_ref_year),
        .i_month (r_ref_month),
        .i_day   (r_ref_day),
        .o_res   (lane_r)
    );

    dd_merge u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vld            (r_vld[2]),
        .i_a              (lane_a),
        .i_b              (lane_b),
        .i_r              (lane_r),
        .o_done           (o_done),
        .o_day_difference (o_day_difference),
        .o_weekday_a      (o_weekday_a),
        .o_weekday_b      (o_weekday_b),
        .o_valid_a        (o_valid_a),
        .o_valid_b        (o_valid_b)
    );

endmodule

`default_nettype wire

// ===== design/dd_lane.sv =====
// One date lane: validity check, day number since 0001-01-01 and its residue mod 7.
// Three register stages. Depends on dd_pkg.
`default_nettype none

module dd_lane (
    input  wire logic                        i_clk,
    input  wire logic [dd_pkg::YEAR_W-1:0]   i_year,
    input  wire logic [dd_pkg::MONTH_W-1:0]  i_month,
    input  wire logic [dd_pkg::DAY_W-1:0]    i_day,
    output dd_pkg::t_lane_res                o_res
);

    logic [dd_pkg::YEAR_W-1:0] n_p;
    logic [dd_pkg::PROD_W-1:0] n_prod_p;
    logic [dd_pkg::PROD_W-1:0] n_prod_y;

    // Stage 1: constant multiplications.
    logic [dd_pkg::YEAR_W-1:0]  r_y;
    logic [dd_pkg::YEAR_W-1:0]  r_p;
    logic [dd_pkg::DNUM_W-1:0]  r_p365;
    logic [dd_pkg::QUOT_W-1:0]  r_qp;
    logic [dd_pkg::QUOT_W-1:0]  r_qy;
    logic [dd_pkg::MONTH_W-1:0] r_m;
    logic [dd_pkg::DAY_W-1:0]   r_d;

    always_comb begin
        n_p = i_year - 14'd1;
        n_prod_p = dd_pkg::PROD_W'(n_p) * dd_pkg::PROD_W'(dd_pkg::DIV100_MUL);
        n_prod_y = dd_pkg::PROD_W'(i_year) * dd_pkg::PROD_W'(dd_pkg::DIV100_MUL);
    end

    always_ff @(posedge i_clk) begin
        r_y <= i_year;
        r_p <= n_p;
        r_p365 <= dd_pkg::DNUM_W'(dd_pkg::DNUM_W'(n_p) * 22'd365);
        r_qp <= dd_pkg::QUOT_W'(n_prod_p >> dd_pkg::DIV100_SHIFT);
        r_qy <= dd_pkg::QUOT_W'(n_prod_y >> dd_pkg::DIV100_SHIFT);
        r_m <= i_month;
        r_d <= i_day;
    end

    // Stage 2: leap rule, range checks and the day number sum.
    logic                      n_cent;
    logic                      n_leap;
    logic                      n_valid;
    logic [dd_pkg::DIFF_W-1:0] n_sum;
    logic                      r_valid2;
    logic [dd_pkg::DNUM_W-1:0] r_n;

    always_comb begin
        n_cent = ({1'b0, r_y} == (15'(r_qy) * 15'd100));
        n_leap = ((r_y[1:0] == 2'd0) && !n_cent) || (n_cent && (r_qy[1:0] == 2'd0));
        n_valid = (r_y >= 14'd1) && (r_y <= dd_pkg::MAX_YEAR)
                  && (r_m inside {[4'd1:4'd12]})
                  && (r_d >= 5'd1) && (r_d <= dd_pkg::month_len(r_m, n_leap));
        n_sum = dd_pkg::DIFF_W'(r_p365) + dd_pkg::DIFF_W'(r_p[13:2])
                - dd_pkg::DIFF_W'(r_qp) + dd_pkg::DIFF_W'(r_qp[7:2])
                + dd_pkg::DIFF_W'(dd_pkg::month_start(r_m)) + dd_pkg::DIFF_W'(r_d)
                - 23'd1 + dd_pkg::DIFF_W'(n_leap && (r_m > 4'd2));
    end

    always_ff @(posedge i_clk) begin
        r_valid2 <= n_valid;
        r_n <= n_sum[dd_pkg::DNUM_W-1:0];
    end

    // Stage 3: residue mod 7 by folding octal digits, since 8 is 1 mod 7.
    logic [23:0] n_ext;
    logic [5:0]  n_s1;
    logic [3:0]  n_s2;
    logic [2:0]  n_r7;

    always_comb begin
        n_ext = {2'b00, r_n};
        n_s1 = 6'(n_ext[2:0]) + 6'(n_ext[5:3]) + 6'(n_ext[8:6]) + 6'(n_ext[11:9])
               + 6'(n_ext[14:12]) + 6'(n_ext[17:15]) + 6'(n_ext[20:18])
               + 6'(n_ext[23:21]);
        n_s2 = 4'(n_s1[5:3]) + 4'(n_s1[2:0]);
        if (n_s2 >= 4'd14) begin
            n_r7 = 3'd0;
        end else if (n_s2 >= 4'd7) begin
            n_r7 = 3'(n_s2 - 4'd7);
        end else begin
            n_r7 = n_s2[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_res.valid <= r_valid2;
        o_res.dnum <= r_n;
        o_res.mod7 <= n_r7;
    end

endmodule

`default_nettype wire

// ===== design/dd_merge.sv =====
// Merge stage: combines the A, B and reference lanes into the result registers.
// Depends on dd_pkg.
`default_nettype none

module dd_merge (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_vld,
    input  wire dd_pkg::t_lane_res                 i_a,
    input  wire dd_pkg::t_lane_res                 i_b,
    input  wire dd_pkg::t_lane_res                 i_r,
    output logic                                   o_done,
    output logic signed [dd_pkg::DIFF_W-1:0]       o_day_difference,
    output logic [dd_pkg::WDAY_W-1:0]              o_weekday_a,
    output logic [dd_pkg::WDAY_W-1:0]              o_weekday_b,
    output logic                                   o_valid_a,
    output logic                                   o_valid_b
);

    logic [dd_pkg::DIFF_W-1:0] n_diff;
    logic [dd_pkg::WDAY_W-1:0] n_wa;
    logic [dd_pkg::WDAY_W-1:0] n_wb;
    logic [3:0]                n_ta;
    logic [3:0]                n_tb;

    always_comb begin
        n_diff = (i_a.valid && i_b.valid)
                 ? ({1'b0, i_a.dnum} - {1'b0, i_b.dnum}) : '0;
        n_ta = 4'(i_a.mod7) + 4'd7 - 4'(i_r.mod7);
        n_tb = 4'(i_b.mod7) + 4'd7 - 4'(i_r.mod7);
        if (n_ta >= 4'd7) begin
            n_ta = n_ta - 4'd7;
        end
        if (n_tb >= 4'd7) begin
            n_tb = n_tb - 4'd7;
        end
        n_wa = (i_r.valid && i_a.valid) ? 3'(n_ta[2:0] + 3'd1) : '0;
        n_wb = (i_r.valid && i_b.valid) ? 3'(n_tb[2:0] + 3'd1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_day_difference <= n_diff;
        o_weekday_a <= n_wa;
        o_weekday_b <= n_wb;
        o_valid_a <= i_a.valid;
        o_valid_b <= i_b.valid;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_date_difference_and_weekday.sv =====
// Self-checking testbench for date_difference_and_weekday.
// Predicts each result with a behavioral calendar model and checks every
// result strobe against it; depends on dd_pkg and the block under test.
`default_nettype none

module tb_date_difference_and_weekday;

    // Clock half period, the pause after the pipe runs dry, and the watchdog limit.
    // The pause outlasts the pipe of the block, so it covers any stray strobe.
    localparam int CLK_HALF = 10;
    localparam int PIPE_DRAIN = 6;
    localparam int CYCLE_LIMIT = 400000;

    // One expected result, at the widths of the result ports.
    typedef struct packed {
        logic signed [dd_pkg::DIFF_W-1:0] diff;
        logic [dd_pkg::WDAY_W-1:0]        wday_a;
        logic [dd_pkg::WDAY_W-1:0]        wday_b;
        logic                             ok_a;
        logic                             ok_b;
    } t_date_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic [dd_pkg::YEAR_W-1:0]           i_year_a;
    logic [dd_pkg::MONTH_W-1:0]          i_month_a;
    logic [dd_pkg::DAY_W-1:0]            i_day_a;
    logic [dd_pkg::YEAR_W-1:0]           i_year_b;
    logic [dd_pkg::MONTH_W-1:0]          i_month_b;
    logic [dd_pkg::DAY_W-1:0]            i_day_b;
    logic                                i_cfg_we;
    logic [dd_pkg::CFG_IDX_W-1:0]        i_cfg_idx;
    logic [dd_pkg::YEAR_W-1:0]           i_cfg_data;
    logic                                o_done;
    logic signed [dd_pkg::DIFF_W-1:0]    o_day_difference;
    logic [dd_pkg::WDAY_W-1:0]           o_weekday_a;
    logic [dd_pkg::WDAY_W-1:0]           o_weekday_b;
    logic                                o_valid_a;
    logic                                o_valid_b;

    // Our copy of the reference date registers. They start at the reset value
    // and follow every register write that the testbench makes.
    logic [dd_pkg::YEAR_W-1:0]  anchor_year = dd_pkg::RST_REF_YEAR;
    logic [dd_pkg::MONTH_W-1:0] anchor_month = dd_pkg::RST_REF_MONTH;
    logic [dd_pkg::DAY_W-1:0]   anchor_day = dd_pkg::RST_REF_DAY;

    // Results that have been predicted for accepted requests, oldest first.
    t_date_result pending_results[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    // Percentage of cycles in which the sender holds off.
    int           idle_pct = 0;

    date_difference_and_weekday i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_year_a         (i_year_a),
        .i_month_a        (i_month_a),
        .i_day_a          (i_day_a),
        .i_year_b         (i_year_b),
        .i_month_b        (i_month_b),
        .i_day_b          (i_day_b),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_done           (o_done),
        .o_day_difference (o_day_difference),
        .o_weekday_a      (o_weekday_a),
        .o_weekday_b      (o_weekday_b),
        .o_valid_a        (o_valid_a),
        .o_valid_b        (o_valid_b)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar arithmetic of the prediction.
    // ------------------------------------------------------------------

    // Gregorian rule: every fourth year, except centuries not divisible by 400.
    function automatic bit is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Length of month m (1..12) in year y.
    function automatic int month_days(input int y, input int m);
        int len;
        case (m)
            2: begin
                len = is_leap(y) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                len = 30;
            end
            default: begin
                len = 31;
            end
        endcase
        return len;
    endfunction

    function automatic bit date_is_valid(input int y, input int m, input int d);
        if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1) begin
            return 1'b0;
        end
        return d <= month_days(y, m);
    endfunction

    // Days in a common year before the first of month m.
    function automatic int days_before_month(input int m);
        int s;
        case (m)
            2: s = 31;
            3: s = 59;
            4: s = 90;
            5: s = 120;
            6: s = 151;
            7: s = 181;
            8: s = 212;
            9: s = 243;
            10: s = 273;
            11: s = 304;
            12: s = 334;
            default: s = 0;
        endcase
        return s;
    endfunction

    // Serial day count from 0001-01-01, which is day zero. Valid dates only.
    function automatic int day_serial(input int y, input int m, input int d);
        int p;
        int n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400 + days_before_month(m) + d - 1;
        if (m > 2 && is_leap(y)) begin
            n = n + 1;
        end
        return n;
    endfunction

    // Weekday 1..7 counted from the anchor day, for dates on either side of it.
    function automatic int weekday_from(input int n, input int anchor);
        int r;
        r = (n - anchor) % 7;
        if (r < 0) begin
            r = r + 7;
        end
        return r + 1;
    endfunction

    // Expected result for one request under the current reference date.
    // Zero fields take the reference field first; then each date is checked.
    // The weekdays need a valid reference date as their origin, while the
    // difference and the valid flags do not.
    function automatic t_date_result predict_dates(input int ya, input int ma, input int da,
                                                   input int yb, input int mb, input int db);
        t_date_result r;
        bit ok_ref;
        int na;
        int nb;
        int nr;
        if (ya == 0) ya = anchor_year;
        if (ma == 0) ma = anchor_month;
        if (da == 0) da = anchor_day;
        if (yb == 0) yb = anchor_year;
        if (mb == 0) mb = anchor_month;
        if (db == 0) db = anchor_day;
        r.ok_a = date_is_valid(ya, ma, da);
        r.ok_b = date_is_valid(yb, mb, db);
        ok_ref = date_is_valid(anchor_year, anchor_month, anchor_day);
        na = r.ok_a ? day_serial(ya, ma, da) : 0;
        nb = r.ok_b ? day_serial(yb, mb, db) : 0;
        nr = ok_ref ? day_serial(anchor_year, anchor_month, anchor_day) : 0;
        r.diff = (r.ok_a && r.ok_b) ? dd_pkg::DIFF_W'(na - nb) : '0;
        r.wday_a = (ok_ref && r.ok_a) ? dd_pkg::WDAY_W'(weekday_from(na, nr)) : '0;
        r.wday_b = (ok_ref && r.ok_b) ? dd_pkg::WDAY_W'(weekday_from(nb, nr)) : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking. Outputs are sampled at the rising edge that ends the
    // strobe cycle, before the block updates them, so the values seen are
    // the ones of that cycle. Each strobe is matched against the oldest
    // predicted result, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_date_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no request pending");
                mismatch_count = mismatch_count + 1;
            end else begin
                want = pending_results.pop_front();
                if (o_day_difference !== want.diff) begin
                    $error("day_difference: expected %0d, actual %0d",
                           $signed(want.diff), o_day_difference);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_weekday_a !== want.wday_a) begin
                    $error("weekday_a: expected %0d, actual %0d", want.wday_a, o_weekday_a);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_weekday_b !== want.wday_b) begin
                    $error("weekday_b: expected %0d, actual %0d", want.wday_b, o_weekday_b);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_valid_a !== want.ok_a) begin
                    $error("valid_a: expected %0d, actual %0d", want.ok_a, o_valid_a);
                    mismatch_count = mismatch_count + 1;
                end
                if (o_valid_b !== want.ok_b) begin
                    $error("valid_b: expected %0d, actual %0d", want.ok_b, o_valid_b);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // Watchdog: a hung pipe or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request driving.
    // ------------------------------------------------------------------

    // Presents one request and holds it until the block takes it. The start
    // line is left high afterwards, so back-to-back requests keep it high
    // without a dip; it is only lowered for idle cycles or by quiesce.
    // Each following cycle is idle with the chance given by idle_pct.
    task automatic send_dates(input int ya, input int ma, input int da,
                              input int yb, input int mb, input int db);
        start <= 1'b1;
        i_year_a <= dd_pkg::YEAR_W'(ya);
        i_month_a <= dd_pkg::MONTH_W'(ma);
        i_day_a <= dd_pkg::DAY_W'(da);
        i_year_b <= dd_pkg::YEAR_W'(yb);
        i_month_b <= dd_pkg::MONTH_W'(mb);
        i_day_b <= dd_pkg::DAY_W'(db);
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_results.push_back(predict_dates(ya, ma, da, yb, mb, db));
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Stops requests and waits until every predicted result has come back,
    // then lets the pipe run empty.
    task automatic quiesce();
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // Writes all three reference registers while the block is idle.
    task automatic set_reference(input int y, input int m, input int d);
        logic [dd_pkg::CFG_IDX_W-1:0] reg_idx;
        int                           data;
        quiesce();
        reg_idx = dd_pkg::REG_REF_YEAR;
        repeat (3) begin
            case (reg_idx)
                dd_pkg::REG_REF_YEAR: data = y;
                dd_pkg::REG_REF_MONTH: data = m;
                default: data = d;
            endcase
            i_cfg_we <= 1'b1;
            i_cfg_idx <= reg_idx;
            i_cfg_data <= dd_pkg::YEAR_W'(data);
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            reg_idx = reg_idx + 1'b1;
        end
        anchor_year = dd_pkg::YEAR_W'(y);
        anchor_month = dd_pkg::MONTH_W'(m);
        anchor_day = dd_pkg::DAY_W'(d);
    endtask

    // One random date. Most are well-formed with random content; the rest
    // hit leap days, the ends of the year range, reference substitution,
    // bad months, days past the month end, and raw field noise.
    task automatic random_date(output int y, output int m, output int d);
        int pick;
        pick = $urandom_range(0, 99);
        y = $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, month_days(y, m));
        if (pick < 3) begin
            y = 100 * $urandom_range(1, 99);
            m = 2;
            d = 29;
        end else if (pick < 8) begin
            y = 4 * $urandom_range(1, 2499);
            m = 2;
            d = 29;
        end else if (pick < 14) begin
            y = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
        end else if (pick < 24) begin
            if ($urandom_range(0, 1)) y = 0;
            if ($urandom_range(0, 1)) m = 0;
            if ($urandom_range(0, 1)) d = 0;
        end else if (pick < 30) begin
            m = $urandom_range(13, 15);
        end else if (pick < 38) begin
            d = $urandom_range(28, 31);
        end else if (pick < 44) begin
            y = $urandom_range(0, 9999);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Widest dates and field values under the reset reference 2001-01-01.
    task automatic test_extremes();
        send_dates(2001, 1, 1, 2001, 1, 1);
        send_dates(9999, 12, 31, 1, 1, 1);
        send_dates(1, 1, 1, 9999, 12, 31);
        send_dates(0, 0, 0, 0, 0, 0);
        send_dates(8191, 7, 16, 4096, 8, 15);
    endtask

    // Leap rule at 400 and 100 year boundaries, years above the range,
    // months above twelve and days past the end of a month.
    task automatic test_calendar_rules();
        send_dates(2000, 2, 29, 1900, 2, 29);
        send_dates(2004, 2, 29, 2003, 2, 29);
        send_dates(16383, 15, 31, 10000, 1, 1);
        send_dates(2001, 13, 1, 2001, 4, 31);
    endtask

    // Mixed substitution of single fields, and both orders of two dates.
    task automatic test_defaults_and_order();
        send_dates(2001, 0, 31, 0, 2, 0);
        send_dates(2024, 6, 15, 1999, 12, 31);
        send_dates(1999, 12, 31, 2024, 6, 15);
    endtask

    // Reference at the last and at the first day of the calendar.
    task automatic test_reference_extremes();
        set_reference(9999, 12, 31);
        send_dates(0, 0, 0, 1, 1, 1);
        send_dates(9999, 12, 30, 0, 0, 0);
        set_reference(1, 1, 1);
        send_dates(0, 0, 0, 9999, 12, 31);
        send_dates(1, 1, 0, 1, 2, 0);
    endtask

    // A reference that is no real date: weekdays go to zero, but the
    // difference and the valid flags are still worked out as usual.
    task automatic test_invalid_reference();
        set_reference(2023, 2, 30);
        send_dates(2023, 3, 1, 0, 0, 0);
        send_dates(2024, 2, 29, 2020, 1, 0);
    endtask

    // Random requests at the given idle rate, in two halves with a fresh
    // reference date each. Between the halves the sender holds off until
    // every result is back, since the registers may only change when idle.
    // About one reference in six is made invalid on purpose.
    task automatic test_random_phase(input int count, input int pct);
        int ry;
        int rm;
        int rd;
        int ya;
        int ma;
        int da;
        int yb;
        int mb;
        int db;
        idle_pct = pct;
        repeat (2) begin
            ry = $urandom_range(1, 9999);
            rm = $urandom_range(1, 12);
            rd = $urandom_range(1, month_days(ry, rm));
            if ($urandom_range(0, 5) == 0) begin
                rm = 2;
                rd = $urandom_range(30, 31);
            end
            set_reference(ry, rm, rd);
            repeat (count / 2) begin
                random_date(ya, ma, da);
                random_date(yb, mb, db);
                send_dates(ya, ma, da, yb, mb, db);
            end
        end
        quiesce();
    endtask

    // ------------------------------------------------------------------
    // Test sequence. Reset is applied once at the start and never
    // again; every input is driven to a known value from time zero.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_year_a <= '0;
        i_month_a <= '0;
        i_day_a <= '0;
        i_year_b <= '0;
        i_month_b <= '0;
        i_day_b <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= dd_pkg::REG_REF_YEAR;
        i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_calendar_rules();
        test_defaults_and_order();
        test_reference_extremes();
        test_invalid_reference();
        test_random_phase(520, 27);
        test_random_phase(520, 68);
        test_random_phase(520, 0);

        // Back to the reset reference, with a last burst of requests.
        set_reference(dd_pkg::RST_REF_YEAR, dd_pkg::RST_REF_MONTH, dd_pkg::RST_REF_DAY);
        send_dates(2001, 1, 7, 2001, 1, 8);
        quiesce();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
